// ===== sv/gmr_pkg.sv =====
// ---------------------------------------------------------------------------
// gmr_pkg: shared types and constants for the GF(2) matrix rank block
// Item layouts for both channels, the flags that travel along the cell
// chain, and the register map of the configuration port.
// ---------------------------------------------------------------------------
`default_nettype none

package gmr_pkg;

   localparam int COLUMN_WIDTH    = 32;
   localparam int ROW_COUNT_WIDTH = 6;
   localparam int ROW_CMP_WIDTH   = ROW_COUNT_WIDTH + 1;
   localparam int RANK_WIDTH      = 6;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 3;

   localparam logic [ROW_COUNT_WIDTH-1:0] ROW_COUNT_RESET = 6'd32;

   // register index, taken from paddr[2]
   localparam logic CSR_ROW_COUNT = 1'b0;

   typedef struct packed {
      logic [COLUMN_WIDTH-1:0] column_bits;
      logic                    last_column;
   } gmr_req_type;

   typedef struct packed {
      logic [RANK_WIDTH-1:0] rank;
      logic                  overflow;
   } gmr_rsp_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic absorbed;
      logic overflow;
   } gmr_flags_type;

endpackage

`default_nettype wire

// ===== sv/gf2_matrix_rank.sv =====
// ---------------------------------------------------------------------------
// gf2_matrix_rank: GF(2) rank of a matrix streamed one column per item
// Masks each column to row_count rows and reduces it along a chain of
// pivot cells; the last column yields the rank and an overflow flag.
// ---------------------------------------------------------------------------
// The block takes one column per clock cycle while input is not held off.
// Each column passes an entry register and then a chain of ROW_BITS pivot
// cells, highest row first; the result for a matrix is registered behind
// the last cell. Columns of the next matrix may follow the last column
// directly. Input is held off only when a result reaches the end of the
// chain while the previous result is still waiting on rsp_stall. Columns
// beyond MAX_COLUMNS in one matrix are dropped and raise overflow.
// row_count is sampled as each column enters.
`default_nettype none

module gf2_matrix_rank
   import gmr_pkg::*;
#(
   parameter int ROW_BITS    = 32,
   parameter int MAX_COLUMNS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // column items
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire gmr_req_type               req_data,
   // rank results
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output gmr_rsp_type                    rsp_data,
   // configuration
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int SEEN_WIDTH     = $clog2(MAX_COLUMNS + 1);
   localparam int RANK_CNT_WIDTH = $clog2(ROW_BITS + 1);

   // ---------------- configuration ----------------
   logic [ROW_COUNT_WIDTH-1:0] row_count_ff;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_ROW_COUNT)) begin
         row_count_ff <= csr_pwdata[ROW_COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_ROW_COUNT) begin
         csr_prdata = CSR_DATA_WIDTH'(row_count_ff);
      end
   end

   // ---------------- entry stage ----------------
   logic                  advance;
   logic                  req_accept;
   logic [ROW_BITS-1:0]   col_ext, row_mask;
   logic [ROW_BITS-1:0]   ent_vec_ff, ent_vec_in;
   gmr_flags_type         ent_flags_ff, ent_flags_in;
   logic [SEEN_WIDTH-1:0] seen_ff, seen_in;
   logic                  too_many_ff, too_many_in;
   logic                  in_range;

   for (genvar i = 0; i < ROW_BITS; i++) begin : g_col
      if (i < COLUMN_WIDTH) begin : g_bit
         assign col_ext[i] = req_data.column_bits[i];
      end else begin : g_pad
         assign col_ext[i] = 1'b0;
      end
      assign row_mask[i] = ({1'b0, row_count_ff} > ROW_CMP_WIDTH'(i));
   end

   assign req_accept = req_valid && advance;
   assign req_stall  = !advance;
   assign in_range   = (seen_ff < SEEN_WIDTH'(MAX_COLUMNS));

   always_comb begin
      ent_vec_in            = in_range ? (col_ext & row_mask) : '0;
      ent_flags_in.valid    = req_valid;
      ent_flags_in.last     = req_data.last_column;
      ent_flags_in.absorbed = 1'b0;
      ent_flags_in.overflow = too_many_ff || !in_range;
      seen_in               = seen_ff;
      too_many_in           = too_many_ff;
      if (req_accept) begin
         if (req_data.last_column) begin
            seen_in     = '0;
            too_many_in = 1'b0;
         end else begin
            seen_in     = seen_ff + SEEN_WIDTH'(in_range);
            too_many_in = too_many_ff || !in_range;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_flags_ff <= '0;
         seen_ff      <= '0;
         too_many_ff  <= 1'b0;
      end else if (advance) begin
         ent_flags_ff <= ent_flags_in;
         seen_ff      <= seen_in;
         too_many_ff  <= too_many_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ent_vec_ff <= ent_vec_in;
      end
   end

   // ---------------- pivot cell chain ----------------
   logic [ROW_BITS-1:0] chain_vec   [ROW_BITS+1];
   gmr_flags_type       chain_flags [ROW_BITS+1];

   assign chain_vec[0]   = ent_vec_ff;
   assign chain_flags[0] = ent_flags_ff;

   for (genvar s = 0; s < ROW_BITS; s++) begin : g_cell
      gmr_cell #(
         .ROW_BITS  (ROW_BITS),
         .BIT_INDEX (ROW_BITS - 1 - s)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_vec    (chain_vec[s]),
         .in_flags  (chain_flags[s]),
         .out_vec   (chain_vec[s+1]),
         .out_flags (chain_flags[s+1])
      );
   end

   // ---------------- rank tally and result register ----------------
   gmr_flags_type                      tail_flags;
   logic [RANK_CNT_WIDTH-1:0]          rank_ff, rank_in, rank_sum;
   logic [RANK_CNT_WIDTH+RANK_WIDTH-1:0] rank_wide;
   logic                               tail_done;
   logic                               rsp_valid_ff, rsp_valid_in;
   gmr_rsp_type                        rsp_data_ff, rsp_data_in;

   assign tail_flags = chain_flags[ROW_BITS];
   assign tail_done  = tail_flags.valid && tail_flags.last;
   // hold the chain only when a second result would land on a waiting one
   assign advance    = !(rsp_valid_ff && rsp_stall && tail_done);

   assign rank_sum  = rank_ff + RANK_CNT_WIDTH'(tail_flags.absorbed);
   assign rank_wide = (RANK_CNT_WIDTH + RANK_WIDTH)'(rank_sum);

   always_comb begin
      rank_in      = rank_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (advance && tail_flags.valid) begin
         if (tail_flags.last) begin
            rank_in              = '0;
            rsp_valid_in         = 1'b1;
            rsp_data_in.rank     = rank_wide[RANK_WIDTH-1:0];
            rsp_data_in.overflow = tail_flags.overflow;
         end else begin
            rank_in = rank_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_result_follows_last : assert property (@(posedge clock) disable iff (reset)
      (advance && tail_done) |=> rsp_valid_ff)
      else $error("last column left the chain without a result");

   a_seen_bounded : assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_WIDTH'(MAX_COLUMNS))
      else $error("column count passed its limit");

   a_too_many_at_limit : assert property (@(posedge clock) disable iff (reset)
      too_many_ff |-> (seen_ff == SEEN_WIDTH'(MAX_COLUMNS)))
      else $error("overflow flagged below the column limit");

   a_matrix_restart : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last_column) |=> ((seen_ff == '0) && !too_many_ff))
      else $error("column count not cleared after last column");

endmodule

`default_nettype wire

// ===== sv/gmr_cell.sv =====
// ---------------------------------------------------------------------------
// gmr_cell: one pivot cell of the elimination chain
// Owns the basis vector whose leading bit is BIT_INDEX. A passing column
// with that bit set is either reduced by the stored vector or, if the cell
// is empty, taken as the new basis vector. The last column of a matrix
// empties the cell behind it.
// ---------------------------------------------------------------------------
`default_nettype none

module gmr_cell
   import gmr_pkg::*;
#(
   parameter int ROW_BITS  = 32,
   parameter int BIT_INDEX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic [ROW_BITS-1:0] in_vec,
   input  wire gmr_flags_type       in_flags,
   output logic      [ROW_BITS-1:0] out_vec,
   output gmr_flags_type            out_flags
);

   logic [ROW_BITS-1:0] basis_ff, basis_in;
   logic                pivot_valid_ff, pivot_valid_in;
   logic [ROW_BITS-1:0] out_vec_ff, out_vec_in;
   gmr_flags_type       out_flags_ff, out_flags_in;

   always_comb begin
      out_vec_in     = in_vec;
      out_flags_in   = in_flags;
      basis_in       = basis_ff;
      pivot_valid_in = pivot_valid_ff;
      if (in_flags.valid && in_vec[BIT_INDEX]) begin
         if (pivot_valid_ff) begin
            out_vec_in = in_vec ^ basis_ff;
         end else begin
            // claim the pivot; the column is used up
            basis_in              = in_vec;
            pivot_valid_in        = 1'b1;
            out_vec_in            = '0;
            out_flags_in.absorbed = 1'b1;
         end
      end
      // end of matrix: drop the basis once the last column has passed
      if (in_flags.valid && in_flags.last) begin
         pivot_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_valid_ff <= 1'b0;
         out_flags_ff   <= '0;
      end else if (advance) begin
         pivot_valid_ff <= pivot_valid_in;
         out_flags_ff   <= out_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         basis_ff   <= basis_in;
         out_vec_ff <= out_vec_in;
      end
   end

   assign out_vec   = out_vec_ff;
   assign out_flags = out_flags_ff;

endmodule

`default_nettype wire
